// File: src/sha1bc_pkg.sv
// Shared types, constants and round functions for the SHA-1 block compression core.
package sha1bc_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds    = 80;
  localparam int unsigned IdxW      = $clog2(BlockWords);
  localparam int unsigned RndW      = $clog2(Rounds);

  localparam logic [WordW-1:0] IV_A = 32'h67452301;
  localparam logic [WordW-1:0] IV_B = 32'hEFCDAB89;
  localparam logic [WordW-1:0] IV_C = 32'h98BADCFE;
  localparam logic [WordW-1:0] IV_D = 32'h10325476;
  localparam logic [WordW-1:0] IV_E = 32'hC3D2E1F0;

  localparam logic [WordW-1:0] K_CH   = 32'h5A827999;
  localparam logic [WordW-1:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K_PAR2 = 32'hCA62C1D6;

  localparam logic [RndW-1:0] RND_PAR1_START = RndW'(20);
  localparam logic [RndW-1:0] RND_MAJ_START  = RndW'(40);
  localparam logic [RndW-1:0] RND_PAR2_START = RndW'(60);
  localparam logic [RndW-1:0] RND_LAST       = RndW'(Rounds - 1);
  localparam logic [IdxW-1:0] IDX_LAST       = IdxW'(BlockWords - 1);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROUND,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } phase_t;

  typedef struct packed {
    logic load;    // shift a new message word into the window
    logic expand;  // shift in the next expanded schedule word
  } sched_ctrl_t;

  typedef struct packed {
    logic   load;  // take working variables from the chaining words
    logic   step;  // run one round
    phase_t phase;
  } round_ctrl_t;

  function automatic logic [WordW-1:0] sha1bc_f(input phase_t ph, input logic [WordW-1:0] b,
                                                input logic [WordW-1:0] c,
                                                input logic [WordW-1:0] d);
    logic [WordW-1:0] res;
    unique case (ph)
      PH_CH:   res = (b & c) | (~b & d);
      PH_MAJ:  res = (b & c) | (b & d) | (c & d);
      default: res = b ^ c ^ d;
    endcase
    return res;
  endfunction

  function automatic logic [WordW-1:0] sha1bc_k(input phase_t ph);
    logic [WordW-1:0] res;
    unique case (ph)
      PH_CH:   res = K_CH;
      PH_PAR1: res = K_PAR1;
      PH_MAJ:  res = K_MAJ;
      default: res = K_PAR2;
    endcase
    return res;
  endfunction

endpackage

// File: src/sha1bc_sched.sv
// Sixteen-word sliding window: collects the block, then expands the message schedule.
module sha1bc_sched import sha1bc_pkg::*; (
  input  logic             clk,
  input  sched_ctrl_t      ctrl,
  input  logic [WordW-1:0] word_in,
  output logic [WordW-1:0] w_cur
);

  logic [WordW-1:0] win [BlockWords];
  logic [WordW-1:0] mix;
  logic [WordW-1:0] expanded;

  // win[0] is w[t]; w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
  assign mix      = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign expanded = {mix[WordW-2:0], mix[WordW-1]};
  assign w_cur    = win[0];

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.expand) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BlockWords-1] <= ctrl.load ? word_in : expanded;
    end
  end

endmodule

// File: src/sha1bc_round.sv
// Shared SHA-1 round unit: five working variables, one round per cycle while step is high.
module sha1bc_round import sha1bc_pkg::*; (
  input  logic             clk,
  input  round_ctrl_t      ctrl,
  input  logic [WordW-1:0] init_a,
  input  logic [WordW-1:0] init_b,
  input  logic [WordW-1:0] init_c,
  input  logic [WordW-1:0] init_d,
  input  logic [WordW-1:0] init_e,
  input  logic [WordW-1:0] w_cur,
  output logic [WordW-1:0] a,
  output logic [WordW-1:0] b,
  output logic [WordW-1:0] c,
  output logic [WordW-1:0] d,
  output logic [WordW-1:0] e
);

  logic [WordW-1:0] t_next;

  assign t_next = {a[WordW-6:0], a[WordW-1:WordW-5]} + sha1bc_f(ctrl.phase, b, c, d) + e
                + sha1bc_k(ctrl.phase) + w_cur;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a <= init_a;
      b <= init_b;
      c <= init_c;
      d <= init_d;
      e <= init_e;
    end else if (ctrl.step) begin
      a <= t_next;
      b <= a;
      c <= {b[1:0], b[WordW-1:2]};
      d <= c;
      e <= d;
    end
  end

endmodule

// File: src/sha1_block_compression.sv
// Operation: the sixteenth word of a block starts the SHA-1 rounds, followed by a finish step that
//   adds the working variables to the chaining words; hash_a..hash_e are registered in that step.
// Throughput: one word per cycle while collecting; in_stall then holds the input through the
//   rounds and the finish step, which waits while the previous result is still stalled.
// Reset: rst (synchronous) loads the SHA-1 initial chaining words, clears the word count
//   and drops any pending result.
module sha1_block_compression import sha1bc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WordW-1:0] msg_word,
  input  logic             start_message,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WordW-1:0] hash_a,
  output logic [WordW-1:0] hash_b,
  output logic [WordW-1:0] hash_c,
  output logic [WordW-1:0] hash_d,
  output logic [WordW-1:0] hash_e
);

  state_t           state, state_next;
  logic [IdxW-1:0]  word_index;
  logic [RndW-1:0]  round_cnt;
  logic [WordW-1:0] chain_a, chain_b, chain_c, chain_d, chain_e;
  logic [WordW-1:0] sum_a, sum_b, sum_c, sum_d, sum_e;
  logic [WordW-1:0] w_cur;
  logic [WordW-1:0] wa, wb, wc, wd, we;
  logic             in_xfer;
  logic             block_done;
  logic             finish_go;
  phase_t           phase;
  sched_ctrl_t      sched_ctrl;
  round_ctrl_t      round_ctrl;

  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    priority if (round_cnt < RND_PAR1_START) phase = PH_CH;
    else if (round_cnt < RND_MAJ_START)      phase = PH_PAR1;
    else if (round_cnt < RND_PAR2_START)     phase = PH_MAJ;
    else                                     phase = PH_PAR2;
  end

  always_comb begin
    state_next        = state;
    in_stall          = 1'b1;
    block_done        = 1'b0;
    finish_go         = 1'b0;
    sched_ctrl.load   = 1'b0;
    sched_ctrl.expand = 1'b0;
    round_ctrl.load   = 1'b0;
    round_ctrl.step   = 1'b0;
    round_ctrl.phase  = phase;
    unique case (state)
      ST_COLLECT: begin
        in_stall        = 1'b0;
        sched_ctrl.load = in_xfer;
        block_done      = in_xfer && !start_message && (word_index == IDX_LAST);
        round_ctrl.load = block_done;
        if (block_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        sched_ctrl.expand = 1'b1;
        round_ctrl.step   = 1'b1;
        if (round_cnt == RND_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        finish_go = !out_valid || !out_stall;
        if (finish_go) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  assign sum_a = chain_a + wa;
  assign sum_b = chain_b + wb;
  assign sum_c = chain_c + wc;
  assign sum_d = chain_d + wd;
  assign sum_e = chain_e + we;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
      chain_a    <= IV_A;
      chain_b    <= IV_B;
      chain_c    <= IV_C;
      chain_d    <= IV_D;
      chain_e    <= IV_E;
      out_valid  <= 1'b0;
    end else begin
      if (in_xfer) begin
        // start word always becomes word 0 of a fresh block
        word_index <= start_message ? IdxW'(1) : word_index + IdxW'(1);
        if (start_message) begin
          chain_a <= IV_A;
          chain_b <= IV_B;
          chain_c <= IV_C;
          chain_d <= IV_D;
          chain_e <= IV_E;
        end
      end
      if (finish_go) begin
        chain_a   <= sum_a;
        chain_b   <= sum_b;
        chain_c   <= sum_c;
        chain_d   <= sum_d;
        chain_e   <= sum_e;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (block_done) begin
      round_cnt <= '0;
    end else if (round_ctrl.step) begin
      round_cnt <= round_cnt + RndW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      hash_a <= sum_a;
      hash_b <= sum_b;
      hash_c <= sum_c;
      hash_d <= sum_d;
      hash_e <= sum_e;
    end
  end

  sha1bc_sched u_sched (
    .clk     (clk),
    .ctrl    (sched_ctrl),
    .word_in (msg_word),
    .w_cur   (w_cur)
  );

  sha1bc_round u_round (
    .clk    (clk),
    .ctrl   (round_ctrl),
    .init_a (chain_a),
    .init_b (chain_b),
    .init_c (chain_c),
    .init_d (chain_d),
    .init_e (chain_e),
    .w_cur  (w_cur),
    .a      (wa),
    .b      (wb),
    .c      (wc),
    .d      (wd),
    .e      (we)
  );

`ifndef SYNTHESIS
  a_round_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> in_stall)
    else $error("input not stalled during rounds");

  a_block_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    block_done |=> (state == ST_ROUND) && (round_cnt == '0))
    else $error("full block did not start the rounds at round zero");

  a_last_round_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) && (round_cnt == RND_LAST) |=> (state == ST_FINISH))
    else $error("rounds did not end after the last round");

  a_finish_posts_result: assert property (@(posedge clk) disable iff (rst)
    finish_go |=> out_valid && (state == ST_COLLECT))
    else $error("finished block produced no result");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && out_valid && out_stall |=> (state == ST_FINISH))
    else $error("pending result overwritten");
`endif

endmodule

// File: sim/sha1_block_compression_tb.sv
// Testbench for sha1_block_compression: streams message words and checks every chaining result.
`timescale 1ns / 100ps

import sha1bc_pkg::*;

class sha1_digest_board;
  logic [WordW-1:0]   chain[5];
  logic [WordW-1:0]   blk[16];
  logic [3:0]         word_pos;
  logic [5*WordW-1:0] digest_q[$];
  int                 mismatches;

  function new();
    chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D; chain[4] = IV_E;
    word_pos = '0;
    mismatches = 0;
  endfunction

  function automatic logic [WordW-1:0] rol(logic [WordW-1:0] x, int n);
    return (x << n) | (x >> (WordW - n));
  endfunction

  // 80-round compression of the gathered block into the chaining words
  function void compress_block();
    logic [WordW-1:0] w[80];
    logic [WordW-1:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) w[r] = blk[r];
    for (int r = 16; r < 80; r++) w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PAR1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_PAR2;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  function void note_word(logic [WordW-1:0] word, logic start);
    if (start) begin
      chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D; chain[4] = IV_E;
      word_pos = '0;
    end
    blk[word_pos] = word;
    word_pos = word_pos + 4'd1;
    if (word_pos == 4'd0) begin
      compress_block();
      digest_q.push_back({chain[0], chain[1], chain[2], chain[3], chain[4]});
    end
  endfunction

  task report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task check_result(logic [5*WordW-1:0] got);
    logic [5*WordW-1:0] want;
    string              names[5];
    names = '{"hash_a", "hash_b", "hash_c", "hash_d", "hash_e"};
    if (digest_q.size() == 0) begin
      report("result transfer with no block pending");
      return;
    end
    want = digest_q.pop_front();
    for (int i = 0; i < 5; i++) begin
      if (got[5*WordW-1-WordW*i -: WordW] !== want[5*WordW-1-WordW*i -: WordW])
        report($sformatf("%s got %08h, want %08h", names[i],
                         got[5*WordW-1-WordW*i -: WordW], want[5*WordW-1-WordW*i -: WordW]));
    end
  endtask

  function int pending();
    return digest_q.size();
  endfunction
endclass

module sha1_block_compression_tb;

  localparam int CycleLimit = 400000;
  localparam int WordTarget = 1770;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [WordW-1:0] msg_word = '0;
  logic             start_message = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [WordW-1:0] hash_a, hash_b, hash_c, hash_d, hash_e;

  sha1_digest_board sb;
  int               cycles = 0;
  bit               send_idle = 1'b1;
  bit               recv_idle = 1'b1;

  sha1_block_compression uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .msg_word      (msg_word),
    .start_message (start_message),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hash_a        (hash_a),
    .hash_b        (hash_b),
    .hash_c        (hash_c),
    .hash_d        (hash_d),
    .hash_e        (hash_e)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({hash_a, hash_b, hash_c, hash_d, hash_e});
    out_stall <= recv_idle && ($urandom_range(99) < 31);
  end

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return WordW'(1) << $urandom_range(WordW - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [WordW-1:0] word, input logic start);
    while (send_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    msg_word      <= word;
    start_message <= start;
    do @(posedge clk); while (in_stall);
    sb.note_word(word, start);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int msg_cnt;
    int kind;
    int n;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // partial block, then a restart mid-block with the one-block "abc" message
    send_word('1, 1'b1);
    send_word('0, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'h6162_6380, 1'b1);
    for (int i = 1; i < 15; i++) send_word('0, 1'b0);
    send_word(32'h0000_0018, 1'b0);
    drain();

    sent = 19;
    msg_cnt = 0;
    while (sent < WordTarget) begin
      msg_cnt++;
      // quiet stretch: no idling on either side
      send_idle = !(msg_cnt >= 20 && msg_cnt < 35);
      recv_idle = send_idle;
      kind = $urandom_range(99);
      if (kind < 78) begin
        n = 16 * $urandom_range(1, 4);
        for (int j = 0; j < n; j++) send_word(pick_word(), j == 0);
      end else if (kind < 88) begin
        // broken message: the next start drops it
        n = $urandom_range(1, 15);
        for (int j = 0; j < n; j++) send_word(pick_word(), j == 0);
      end else if (kind < 95) begin
        // block chained on without a start
        n = 16;
        for (int j = 0; j < n; j++) send_word(pick_word(), 1'b0);
      end else begin
        n = $urandom_range(1, 20);
        for (int j = 0; j < n; j++) send_word(pick_word(), $urandom_range(1) == 1);
      end
      sent += n;
      if ($urandom_range(19) == 0) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
src/sha1bc_pkg.sv
src/sha1bc_sched.sv
src/sha1bc_round.sv
src/sha1_block_compression.sv
sim/sha1_block_compression_tb.sv
